[design/tsa_pkg.sv]
package tsa_pkg;

	localparam int SIDE_W        = 16;
	localparam int DEF_SIDE_BITS = 16;
	localparam int IN_W          = 48;
	localparam int OUT_W         = 80;
	localparam int USER_W        = 1;
	localparam int PER_W         = 18;
	localparam int AREA_W        = 33;
	localparam int ANG_W         = 8;
	localparam int GAM_W         = 9;
	localparam int CNT_W         = 8;
	localparam int ANG_STEPS     = 8;
	localparam int ANG_MAX       = 180;
	localparam int FRAC          = 30;
	localparam int COS_W         = 32;

	localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q60  = 64'h1000000000000000;
	localparam logic [63:0] STEP_Q60 = PI_Q60 / 360;

	typedef logic signed [COS_W-1:0] cos_tab_t [0:ANG_MAX];

	function automatic logic [63:0] mul_q60(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] w;
		w = {64'd0, x} * {64'd0, y};
		return w[123:60];
	endfunction

	function automatic logic [63:0] div_term(input logic [63:0] v, input int n);
		logic [63:0] r;
		unique case (n)
			1: r = v / 2;
			2: r = v / 12;
			3: r = v / 30;
			4: r = v / 56;
			5: r = v / 90;
			6: r = v / 132;
			7: r = v / 182;
			8: r = v / 240;
			9: r = v / 306;
			10: r = v / 380;
			11: r = v / 462;
			12: r = v / 552;
			13: r = v / 650;
			14: r = v / 756;
			15: r = v / 870;
			16: r = v / 992;
			17: r = v / 1122;
			18: r = v / 1260;
			19: r = v / 1406;
			default: r = v / 1560;
		endcase
		return r;
	endfunction

	// Cosine of each half-degree boundary, 30 fractional bits, from a Taylor series.
	function automatic cos_tab_t build_cos_tab();
		cos_tab_t t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] rnd;
		t[0] = '0;
		for (int k = 1; k <= 90; k++) begin
			x = 64'(2 * k - 1) * STEP_Q60;
			x2 = mul_q60(x, x);
			term = ONE_Q60;
			sum = ONE_Q60;
			for (int n = 1; n <= 20; n++) begin
				term = div_term(mul_q60(term, x2), n);
				if ((n % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			rnd = (sum + 64'h20000000) >> FRAC;
			t[k] = COS_W'(rnd);
			t[ANG_MAX + 1 - k] = -COS_W'(rnd);
		end
		return t;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

[design/tsa_delay.sv]
module tsa_delay import tsa_pkg::*; #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	generate
		if (D == 0) begin : g_none
			assign dout = din;
		end else begin : g_line
			logic [W-1:0] line_q [0:D-1];
			always_ff @(posedge clk) begin
				if (en) begin
					line_q[0] <= din;
					for (int i = 1; i < D; i++) begin
						line_q[i] <= line_q[i-1];
					end
				end
			end
			assign dout = line_q[D-1];
		end
	endgenerate

endmodule

[design/tsa_sqrt_cell.sv]
module tsa_sqrt_cell import tsa_pkg::*; #(
	parameter int NW = 70,
	parameter int RW = 35
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] op_i,
	input  logic [RW+1:0] rem_i,
	input  logic [RW-1:0] root_i,
	output logic [NW-1:0] op_o,
	output logic [RW+1:0] rem_o,
	output logic [RW-1:0] root_o
);

	logic [RW+3:0] cur;
	logic [RW+3:0] trial;
	logic [RW+3:0] diff;
	logic          ge;

	assign cur   = {rem_i, op_i[NW-1 -: 2]};
	assign trial = {2'b00, root_i, 2'b01};
	assign ge    = cur >= trial;
	assign diff  = cur - trial;

	always_ff @(posedge clk) begin
		if (en) begin
			op_o   <= {op_i[NW-3:0], 2'b00};
			rem_o  <= ge ? diff[RW+1:0] : cur[RW+1:0];
			root_o <= {root_i[RW-2:0], ge};
		end
	end

endmodule

[design/tsa_angle_cell.sv]
module tsa_angle_cell import tsa_pkg::*; #(
	parameter int NUMW    = 34,
	parameter int BIT_POS = 7
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [CNT_W-1:0]       cnt_i,
	input  logic signed [NUMW-1:0] num_i,
	input  logic signed [NUMW-1:0] den_i,
	output logic [CNT_W-1:0]       cnt_o,
	output logic signed [NUMW-1:0] num_o,
	output logic signed [NUMW-1:0] den_o
);

	localparam int CW = COS_W + NUMW;

	logic [CNT_W-1:0]       t;
	logic                   t_ok;
	logic [CNT_W-1:0]       idx;
	logic signed [CW-1:0]   rhs;
	logic signed [CW-1:0]   lhs;

	logic [CNT_W-1:0]       t_q;
	logic                   ok_q;
	logic signed [CW-1:0]   rhs_q;
	logic [CNT_W-1:0]       cnt_q;
	logic signed [NUMW-1:0] num_q;
	logic signed [NUMW-1:0] den_q;

	assign t    = cnt_i | CNT_W'(1 << BIT_POS);
	assign t_ok = t <= CNT_W'(ANG_MAX);
	assign idx  = t_ok ? t : '0;
	assign rhs  = COS_TAB[idx] * den_i;
	assign lhs  = signed'({{(CW - NUMW - FRAC){num_q[NUMW-1]}}, num_q, {FRAC{1'b0}}});

	always_ff @(posedge clk) begin
		if (en) begin
			t_q   <= t;
			ok_q  <= t_ok;
			rhs_q <= rhs;
			cnt_q <= cnt_i;
			num_q <= num_i;
			den_q <= den_i;
			cnt_o <= (ok_q && (lhs <= rhs_q)) ? t_q : cnt_q;
			num_o <= num_q;
			den_o <= den_q;
		end
	end

endmodule

[design/triangle_sides_to_area_and_angles.sv]
// Triangle sides in, perimeter, Heron area and rounded angles out.
// The slave channel takes one word of three unsigned sides per cycle; the
// master channel returns one word per input word, in the same order. A word
// whose sides break the strict triangle inequality comes back with the flag
// in tuser clear and all data fields zero.
// The pipeline depth is set by the longer of two paths: the square root, a
// row of cells that settles one root bit each, and the angle search, two
// rows of eight binary-search cells of two stages each, running beside it.
// Throughput is one word per cycle.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and tready on the slave side drops until the result is taken.
// Reset empties the pipeline; no result is shown until a new word arrives.
module triangle_sides_to_area_and_angles import tsa_pkg::*; #(
	parameter int SIDE_BITS = DEF_SIDE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,  // side_a, side_b, side_c
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,  // perimeter, area_x4, alpha, beta, gamma
	output logic [USER_W-1:0] m_tuser   // is_triangle
);

	localparam int S    = SIDE_BITS;
	localparam int PW   = S + 2;
	localparam int FW   = S + 1;
	localparam int QW   = 2 * S;
	localparam int UW   = PW + FW;
	localparam int VW   = 2 * FW;
	localparam int NW0  = UW + VW;
	localparam int NW   = NW0 + (NW0 % 2);
	localparam int RW   = NW / 2;
	localparam int NUMW = QW + 2;
	localparam int ST   = 5 + RW;
	localparam int AT   = 3 + 2 * ANG_STEPS;
	localparam int T    = (ST > AT) ? ST : AT;

	logic en;
	logic vld_q [1:T+1];

	assign en       = !vld_q[T+1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[T+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= T + 1; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[1] <= s_tvalid;
			for (int i = 2; i <= T + 1; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	logic [S-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= s_tdata[S-1:0];
			b_s1 <= s_tdata[SIDE_W + S - 1 : SIDE_W];
			c_s1 <= s_tdata[2 * SIDE_W + S - 1 : 2 * SIDE_W];
		end
	end

	logic [FW-1:0] sab, sac, sbc;
	logic          tri_s2;
	logic [PW-1:0] p_s2;
	logic [FW-1:0] x_s2, y_s2, z_s2;
	logic [QW-1:0] a2_s2, b2_s2, c2_s2, bc_s2, ac_s2;

	assign sab = FW'(a_s1) + FW'(b_s1);
	assign sac = FW'(a_s1) + FW'(c_s1);
	assign sbc = FW'(b_s1) + FW'(c_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			tri_s2 <= (FW'(a_s1) < sbc) && (FW'(b_s1) < sac) && (FW'(c_s1) < sab);
			p_s2   <= PW'(sab) + PW'(c_s1);
			x_s2   <= sbc - FW'(a_s1);
			y_s2   <= sac - FW'(b_s1);
			z_s2   <= sab - FW'(c_s1);
			a2_s2  <= a_s1 * a_s1;
			b2_s2  <= b_s1 * b_s1;
			c2_s2  <= c_s1 * c_s1;
			bc_s2  <= b_s1 * c_s1;
			ac_s2  <= a_s1 * c_s1;
		end
	end

	logic                   tri_s3;
	logic [PW-1:0]          p_s3;
	logic [UW-1:0]          u_s3;
	logic [VW-1:0]          v_s3;
	logic signed [NUMW-1:0] numa_s3, dena_s3, numb_s3, denb_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			tri_s3  <= tri_s2;
			p_s3    <= p_s2;
			u_s3    <= p_s2 * x_s2;
			v_s3    <= y_s2 * z_s2;
			numa_s3 <= signed'(NUMW'(b2_s2) + NUMW'(c2_s2) - NUMW'(a2_s2));
			numb_s3 <= signed'(NUMW'(a2_s2) + NUMW'(c2_s2) - NUMW'(b2_s2));
			dena_s3 <= signed'({1'b0, bc_s2, 1'b0});
			denb_s3 <= signed'({1'b0, ac_s2, 1'b0});
		end
	end

	logic [UW+FW-1:0] lo_s4, hi_s4;
	logic [NW-1:0]    n_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s4 <= u_s3 * v_s3[FW-1:0];
			hi_s4 <= u_s3 * v_s3[VW-1:FW];
			n_s5  <= NW'({hi_s4, {FW{1'b0}}}) + NW'(lo_s4);
		end
	end

	logic [NW-1:0] op_c   [0:RW];
	logic [RW+1:0] rem_c  [0:RW];
	logic [RW-1:0] root_c [0:RW];

	assign op_c[0]   = n_s5;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		tsa_sqrt_cell #(.NW(NW), .RW(RW)) u_cell (
			.clk    (clk),
			.en     (en),
			.op_i   (op_c[i]),
			.rem_i  (rem_c[i]),
			.root_i (root_c[i]),
			.op_o   (op_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.root_o (root_c[i+1])
		);
	end

	logic [CNT_W-1:0]       ca [0:ANG_STEPS];
	logic [CNT_W-1:0]       cb [0:ANG_STEPS];
	logic signed [NUMW-1:0] na [0:ANG_STEPS];
	logic signed [NUMW-1:0] da [0:ANG_STEPS];
	logic signed [NUMW-1:0] nb [0:ANG_STEPS];
	logic signed [NUMW-1:0] db [0:ANG_STEPS];

	assign ca[0] = '0;
	assign cb[0] = '0;
	assign na[0] = numa_s3;
	assign da[0] = dena_s3;
	assign nb[0] = numb_s3;
	assign db[0] = denb_s3;

	for (genvar j = 0; j < ANG_STEPS; j++) begin : g_ang
		tsa_angle_cell #(.NUMW(NUMW), .BIT_POS(ANG_STEPS - 1 - j)) u_alpha (
			.clk   (clk),
			.en    (en),
			.cnt_i (ca[j]),
			.num_i (na[j]),
			.den_i (da[j]),
			.cnt_o (ca[j+1]),
			.num_o (na[j+1]),
			.den_o (da[j+1])
		);
		tsa_angle_cell #(.NUMW(NUMW), .BIT_POS(ANG_STEPS - 1 - j)) u_beta (
			.clk   (clk),
			.en    (en),
			.cnt_i (cb[j]),
			.num_i (nb[j]),
			.den_i (db[j]),
			.cnt_o (cb[j+1]),
			.num_o (nb[j+1]),
			.den_o (db[j+1])
		);
	end

	logic [RW-1:0]        root_d;
	logic [2*CNT_W-1:0]   ang_d;
	logic [PW:0]          meta_d;

	tsa_delay #(.W(RW), .D(T - ST)) u_dly_root (
		.clk (clk), .en (en), .din (root_c[RW]), .dout (root_d)
	);

	tsa_delay #(.W(2 * CNT_W), .D(T - AT)) u_dly_ang (
		.clk (clk), .en (en), .din ({cb[ANG_STEPS], ca[ANG_STEPS]}), .dout (ang_d)
	);

	tsa_delay #(.W(PW + 1), .D(T - 3)) u_dly_meta (
		.clk (clk), .en (en), .din ({tri_s3, p_s3}), .dout (meta_d)
	);

	logic                tri_q;
	logic [PER_W-1:0]    per_q;
	logic [AREA_W-1:0]   area_q;
	logic [ANG_W-1:0]    alpha_q, beta_q;
	logic [GAM_W-1:0]    gamma_q;
	logic [ANG_W-1:0]    alpha_w, beta_w;

	assign alpha_w = ANG_W'(ang_d[CNT_W-1:0]);
	assign beta_w  = ANG_W'(ang_d[2*CNT_W-1:CNT_W]);

	always_ff @(posedge clk) begin
		if (en) begin
			tri_q <= meta_d[PW];
			if (meta_d[PW]) begin
				per_q   <= PER_W'(meta_d[PW-1:0]);
				area_q  <= AREA_W'(root_d);
				alpha_q <= alpha_w;
				beta_q  <= beta_w;
				gamma_q <= GAM_W'(ANG_MAX) - GAM_W'(alpha_w) - GAM_W'(beta_w);
			end else begin
				per_q   <= '0;
				area_q  <= '0;
				alpha_q <= '0;
				beta_q  <= '0;
				gamma_q <= '0;
			end
		end
	end

	assign m_tuser = tri_q;
	assign m_tdata = OUT_W'({gamma_q, beta_q, alpha_q, area_q, per_q});

endmodule

[tb/sv/tb.sv]
module tb;
	import tsa_pkg::*;

	typedef struct {
		logic                    valid_tri;
		logic [PER_W-1:0]        per;
		logic [AREA_W-1:0]       area;
		logic [ANG_W-1:0]        alpha;
		logic [ANG_W-1:0]        beta;
		logic signed [GAM_W-1:0] gamma;
	} tri_res_t;

	typedef struct {
		logic [SIDE_W-1:0] a;
		logic [SIDE_W-1:0] b;
		logic [SIDE_W-1:0] c;
		bit                typed;
		tri_res_t          res;
	} tri_row_t;

	localparam int WATCHDOG = 5000;
	localparam int RAND_WORDS = 550;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic [USER_W-1:0] m_tuser;

	longint   cos_edge [0:ANG_MAX];
	tri_res_t pending_shapes [$];
	int       errors = 0;
	int       quiet_cycles = 0;
	bit       hold_done = 0;

	triangle_sides_to_area_and_angles i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] fix_mul(logic [63:0] x, logic [63:0] y);
		logic [127:0] w;
		w = {64'd0, x} * {64'd0, y};
		return w[123:60];
	endfunction

	function automatic void fill_cos_edges();
		logic [63:0] pi_q, step, x, x2, term, sum;
		pi_q = 64'h3243F6A8885A308D;
		step = pi_q / 360;
		cos_edge[0] = 0;
		for (int k = 1; k <= 90; k++) begin
			x = 64'(2 * k - 1) * step;
			x2 = fix_mul(x, x);
			term = 64'd1 << 60;
			sum = 64'd1 << 60;
			for (int n = 1; n <= 20; n++) begin
				term = fix_mul(term, x2) / 64'((2 * n - 1) * (2 * n));
				if (n % 2) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			cos_edge[k] = longint'((sum + 64'h20000000) >> 30);
			cos_edge[181 - k] = -cos_edge[k];
		end
	endfunction

	function automatic int round_degrees(longint num, longint den);
		int cnt;
		cnt = 0;
		for (int k = 1; k <= ANG_MAX; k++) begin
			if (num * 64'sd1073741824 <= cos_edge[k] * den) begin
				cnt++;
			end
		end
		return cnt;
	endfunction

	function automatic tri_res_t solve_triangle(logic [SIDE_W-1:0] a, logic [SIDE_W-1:0] b,
			logic [SIDE_W-1:0] c);
		tri_res_t r;
		longint sa, sb, sc;
		logic [127:0] prod, t;
		logic [63:0] root;
		int al, be;
		r = '{default: '0};
		sa = a;
		sb = b;
		sc = c;
		if (!(sa < sb + sc && sb < sa + sc && sc < sa + sb)) begin
			return r;
		end
		prod = 128'(sa + sb + sc) * 128'(sb + sc - sa) * 128'(sa + sc - sb) * 128'(sa + sb - sc);
		root = 0;
		for (int i = 36; i >= 0; i--) begin
			t = 128'(root | (64'd1 << i));
			if (t * t <= prod) begin
				root = t[63:0];
			end
		end
		al = round_degrees(sb * sb + sc * sc - sa * sa, 2 * sb * sc);
		be = round_degrees(sa * sa + sc * sc - sb * sb, 2 * sa * sc);
		r.valid_tri = 1;
		r.per = PER_W'(sa + sb + sc);
		r.area = AREA_W'(root);
		r.alpha = ANG_W'(al);
		r.beta = ANG_W'(be);
		r.gamma = GAM_W'(180 - al - be);
		return r;
	endfunction

	task automatic offer_sides(logic [SIDE_W-1:0] a, logic [SIDE_W-1:0] b, logic [SIDE_W-1:0] c,
			bit typed, tri_res_t res);
		tri_res_t want;
		int gap;
		if ($urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		want = typed ? res : solve_triangle(a, b, c);
		s_tvalid <= 1;
		s_tdata <= {c, b, a};
		do @(posedge clk); while (!s_tready);
		pending_shapes.push_back(want);
	endtask

	task automatic random_shape();
		int a, b, c, lim;
		case ($urandom_range(0, 9))
			0: begin
				a = $urandom_range(0, 65535);
				b = $urandom_range(0, 65535);
				c = $urandom_range(0, 65535);
			end
			1, 2: begin
				a = $urandom_range(1, 12);
				b = $urandom_range(1, 12);
				c = $urandom_range(1, 12);
			end
			default: begin
				lim = ($urandom_range(0, 2) == 0) ? 65535 : (1 << $urandom_range(2, 16)) - 1;
				a = $urandom_range(1, lim);
				b = $urandom_range(1, lim);
				c = $urandom_range(((a > b) ? a - b : b - a) + 1,
					(a + b - 1 > 65535) ? 65535 : a + b - 1);
			end
		endcase
		offer_sides(a, b, c, 0, '{default: '0});
	endtask

	// Receiver: random stalls, and one long hold-off to fill the pipeline.
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		repeat (30) begin
			m_tready <= 1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			m_tready <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		m_tready <= 0;
		n = 0;
		while (n < 300) begin
			@(posedge clk);
			n++;
		end
		hold_done = 1;
		forever begin
			m_tready <= 1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if ($urandom_range(0, 2) == 0) begin
				m_tready <= 0;
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
					: $urandom_range(1, 3)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		tri_res_t want;
		logic signed [GAM_W-1:0] g;
		if (m_tvalid && m_tready) begin
			if (pending_shapes.size() == 0) begin
				$display("%0t unexpected word %h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_shapes.pop_front();
				g = m_tdata[75:67];
				if (m_tuser[0] !== want.valid_tri) begin
					$display("%0t is_triangle exp %0d got %0d", $time, want.valid_tri, m_tuser[0]);
					errors++;
				end
				if (m_tdata[17:0] !== want.per) begin
					$display("%0t perimeter exp %0d got %0d", $time, want.per, m_tdata[17:0]);
					errors++;
				end
				if (m_tdata[50:18] !== want.area) begin
					$display("%0t area_x4 exp %0d got %0d", $time, want.area, m_tdata[50:18]);
					errors++;
				end
				if (m_tdata[58:51] !== want.alpha) begin
					$display("%0t alpha exp %0d got %0d", $time, want.alpha, m_tdata[58:51]);
					errors++;
				end
				if (m_tdata[66:59] !== want.beta) begin
					$display("%0t beta exp %0d got %0d", $time, want.beta, m_tdata[66:59]);
					errors++;
				end
				if (g !== want.gamma) begin
					$display("%0t gamma exp %0d got %0d", $time, want.gamma, g);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG) begin
			$display("triangle_sides_to_area_and_angles: mismatch");
			$finish;
		end
	end

	initial begin
		tri_row_t rows [$];
		tri_res_t none;
		none = '{default: '0};
		rows = '{
			'{16'd0, 16'd0, 16'd0, 1, none},
			'{16'd0, 16'd5, 16'd5, 1, none},
			'{16'd1, 16'd2, 16'd3, 1, none},
			'{16'd65535, 16'd1, 16'd1, 1, none},
			'{16'd1, 16'd65535, 16'd1, 1, none},
			'{16'd1, 16'd1, 16'd65535, 1, none},
			'{16'd65535, 16'd65535, 16'd0, 1, none},
			'{16'd1, 16'd1, 16'd1, 0, none},
			'{16'd65535, 16'd65535, 16'd65535, 0, none},
			'{16'd65535, 16'd65535, 16'd1, 0, none},
			'{16'd1, 16'd65535, 16'd65535, 0, none},
			'{16'd3, 16'd4, 16'd5, 0, none},
			'{16'd5, 16'd3, 16'd4, 0, none},
			'{16'd2, 16'd2, 16'd3, 0, none},
			'{16'd32768, 16'd32767, 16'd65534, 0, none},
			'{16'd43690, 16'd21845, 16'd65535, 1, none},
			'{16'd2, 16'd3, 16'd4, 0, none},
			'{16'd7, 16'd7, 16'd13, 0, none},
			'{16'd100, 16'd1, 16'd100, 0, none}
		};
		fill_cos_edges();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) begin
			offer_sides(rows[i].a, rows[i].b, rows[i].c, rows[i].typed, rows[i].res);
		end
		for (int i = 0; i < RAND_WORDS; i++) begin
			random_shape();
		end
		while (!hold_done) begin
			random_shape();
		end
		s_tvalid <= 0;
		while (pending_shapes.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("triangle_sides_to_area_and_angles: match");
		end else begin
			$display("triangle_sides_to_area_and_angles: mismatch");
		end
		$finish;
	end
endmodule

[sim.f]
design/tsa_pkg.sv
design/tsa_delay.sv
design/tsa_sqrt_cell.sv
design/tsa_angle_cell.sv
design/triangle_sides_to_area_and_angles.sv
tb/sv/tb.sv
